// File: hw/rtl/bdd_pkg.sv
// ----------------------------------------------------------------------------
// bdd_pkg: shared types and constants for the BDD unique node table
// Request and result payloads, hash constants and the front-to-back job type.
// ----------------------------------------------------------------------------
`default_nettype none
package bdd_pkg;

  typedef struct packed {
    logic [7:0]  decision_var;
    logic [15:0] low_child;
    logic [15:0] high_child;
  } bdd_req_t;

  typedef struct packed {
    logic [15:0] node_id;
    logic        created;
    logic        exhausted;
  } bdd_rsp_t;

  // Job handed from the front (hash) to the back (walk and insert).
  typedef struct packed {
    bdd_req_t    req;
    logic        trivial;
    logic [31:0] hash;
  } bdd_job_t;

  localparam logic [63:0] HASH_BASIS = 64'd1469598103934665603;
  localparam logic [63:0] HASH_PRIME = 64'd1099511628211;

endpackage
`default_nettype wire

// File: hw/rtl/bdd_ram.sv
// ----------------------------------------------------------------------------
// bdd_ram: generic single-port RAM
// One read per cycle plus a write when we is set; registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module bdd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/bdd_front.sv
// ----------------------------------------------------------------------------
// bdd_front: request intake and hashing
// Runs the three-word FNV-style hash, one 32x32 partial product per cycle between x load steps.
// ----------------------------------------------------------------------------
`default_nettype none
module bdd_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire bdd_pkg::bdd_req_t in_data,
  output logic                   job_valid,
  input  wire logic              job_ready,
  output bdd_pkg::bdd_job_t      job
);
  import bdd_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DONE} state_t;

  state_t      state_r;
  bdd_req_t    req_r;
  logic [63:0] h_r, x_r, acc_r;
  logic [1:0]  word_r;   // which input word is being folded in
  logic [1:0]  part_r;   // partial product step

  logic [63:0] x_nxt;
  logic [31:0] a_part, b_part;
  logic [63:0] prod;
  logic [63:0] shifted;

  always_comb begin
    unique case (word_r)
      2'd0:    x_nxt = h_r ^ {56'd0, req_r.decision_var};
      2'd1:    x_nxt = h_r ^ {48'd0, req_r.low_child};
      default: x_nxt = h_r ^ {48'd0, req_r.high_child};
    endcase
  end

  // Partial products of x * prime truncated to 64 bits: lo*lo, hi*lo, lo*hi.
  always_comb begin
    unique case (part_r)
      2'd0:    begin a_part = x_r[31:0];  b_part = HASH_PRIME[31:0];  end
      2'd1:    begin a_part = x_r[63:32]; b_part = HASH_PRIME[31:0];  end
      default: begin a_part = x_r[31:0];  b_part = HASH_PRIME[63:32]; end
    endcase
    prod = {32'd0, a_part} * {32'd0, b_part};
    shifted = (part_r == 2'd0) ? prod : {prod[31:0], 32'd0};
  end

  assign in_full   = (state_r != S_IDLE);
  assign job_valid = (state_r == S_DONE);
  assign job.req     = req_r;
  assign job.trivial = (req_r.low_child == req_r.high_child);
  assign job.hash    = h_r[31:0] ^ h_r[63:32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      word_r  <= 2'd0;
      part_r  <= 2'd0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_push) begin
            req_r  <= in_data;
            h_r    <= HASH_BASIS;
            word_r <= 2'd0;
            part_r <= 2'd3;   // load x first
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (part_r == 2'd3) begin
            x_r    <= x_nxt;
            acc_r  <= 64'd0;
            part_r <= 2'd0;
          end else if (part_r == 2'd2) begin
            h_r    <= acc_r + shifted;
            part_r <= 2'd3;
            if (word_r == 2'd2) begin
              state_r <= S_DONE;
            end else begin
              word_r <= word_r + 2'd1;
            end
          end else begin
            acc_r  <= acc_r + shifted;
            part_r <= part_r + 2'd1;
          end
        end
        default: begin
          if (job_ready) begin
            state_r <= S_IDLE;
          end
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/bdd_queue.sv
// ----------------------------------------------------------------------------
// bdd_queue: two-entry job queue between front and back
// Lets the front hash the next request while the back walks a chain.
// ----------------------------------------------------------------------------
`default_nettype none
module bdd_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_valid,
  output logic                   wr_ready,
  input  wire bdd_pkg::bdd_job_t wr_job,
  output logic                   rd_valid,
  input  wire logic              rd_ready,
  output bdd_pkg::bdd_job_t      rd_job
);
  import bdd_pkg::*;

  bdd_job_t   slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_job   = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) begin
      slot_r[wp_r] <= wr_job;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= ~wp_r;
      if (rd_valid && rd_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_valid && wr_ready} - {1'b0, rd_valid && rd_ready};
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/bdd_back.sv
// ----------------------------------------------------------------------------
// bdd_back: chain walk and node insertion
// Clears bucket table after reset, walks each chain in node memory, adds a
// new node at the chain head on a miss unless refused; one-entry result slot.
// ----------------------------------------------------------------------------
`default_nettype none
module bdd_back #(
  parameter int NODE_CAPACITY = 65536,
  parameter int BUCKET_BITS   = 17
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [16:0]       budget_limit,
  input  wire logic              job_valid,
  output logic                   job_ready,
  input  wire bdd_pkg::bdd_job_t job,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output bdd_pkg::bdd_rsp_t      out_data
);
  import bdd_pkg::*;

  localparam int IW = $clog2(NODE_CAPACITY);
  localparam int CW = IW + 1;
  localparam int BW = BUCKET_BITS;
  localparam int NW = 8 + 32 + IW;   // var, low, high, link

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HEAD, S_CHECK, S_NODE, S_LINK, S_OUT
  } state_t;

  state_t       state_r;
  bdd_job_t     job_r;
  logic [BW-1:0] clr_r;
  logic [CW-1:0] count_r;
  logic [IW-1:0] cur_r;
  bdd_rsp_t     res_r;
  bdd_rsp_t     rsp_r;
  logic         rsp_valid_r;

  logic          bk_we;
  logic [BW-1:0] bk_addr;
  logic [IW-1:0] bk_wdata, bk_rdata;
  logic          nd_we;
  logic [IW-1:0] nd_addr;
  logic [NW-1:0] nd_wdata, nd_rdata;

  logic [BW-1:0] bucket;
  logic          refuse;
  logic [IW-1:0] new_id;

  assign bucket = job_r.hash[BW-1:0];
  assign new_id = count_r[IW-1:0];
  assign refuse = ((budget_limit != 17'd0) && ({{(32-17){1'b0}}, budget_limit} <=
                   {{(32-CW){1'b0}}, count_r})) ||
                  (count_r >= CW'(NODE_CAPACITY));

  bdd_ram #(.WIDTH(IW), .DEPTH(1 << BW)) u_heads (
    .clk(clk), .we(bk_we), .addr(bk_addr), .wdata(bk_wdata), .rdata(bk_rdata)
  );
  bdd_ram #(.WIDTH(NW), .DEPTH(NODE_CAPACITY)) u_nodes (
    .clk(clk), .we(nd_we), .addr(nd_addr), .wdata(nd_wdata), .rdata(nd_rdata)
  );

  always_comb begin
    bk_we    = 1'b0;
    bk_addr  = bucket;
    bk_wdata = new_id;
    nd_we    = 1'b0;
    nd_addr  = cur_r;
    nd_wdata = {job_r.req.decision_var, job_r.req.low_child,
                job_r.req.high_child, cur_r};
    priority case (state_r)
      S_CLEAR: begin
        bk_we    = 1'b1;
        bk_addr  = clr_r;
        bk_wdata = '0;
      end
      S_LINK: begin
        // cur_r holds the chain head (S_CHECK or S_NODE); new node links to it
        bk_we    = 1'b1;
        nd_we    = 1'b1;
        nd_addr  = new_id;
      end
      default: ;
    endcase
  end

  assign job_ready = (state_r == S_IDLE);
  assign out_empty = ~rsp_valid_r;
  assign out_data  = rsp_r;

  logic [IW-1:0] head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      count_r     <= CW'(2);
      rsp_valid_r <= 1'b0;
    end else begin
      if (state_r == S_OUT && (!rsp_valid_r || out_pop)) begin
        rsp_valid_r <= 1'b1;
      end else if (out_pop && rsp_valid_r) begin
        rsp_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == {BW{1'b1}}) state_r <= S_IDLE;
        end
        S_IDLE: begin
          head_r <= '0;
          if (job_valid) begin
            job_r <= job;
            if (job.trivial) begin
              res_r   <= '{node_id: job.req.low_child, created: 1'b0, exhausted: 1'b0};
              state_r <= S_OUT;
            end else begin
              state_r <= S_HEAD;
            end
          end
        end
        // first pass waits on the bucket read; during a walk wait on the node read
        S_HEAD: state_r <= (cur_r != '0 && head_r != '0) ? S_NODE : S_CHECK;
        S_CHECK: begin
          // first visit: take head from bucket RAM
          head_r  <= bk_rdata;
          cur_r   <= bk_rdata;
          if (bk_rdata != '0) begin
            state_r <= S_HEAD;
          end else if (refuse) begin
            res_r   <= '{node_id: 16'd0, created: 1'b0, exhausted: 1'b1};
            state_r <= S_OUT;
          end else begin
            state_r <= S_LINK;
          end
        end
        S_NODE: begin
          // node read issued last cycle at cur_r; compare this cycle when data lands
          if (nd_rdata[NW-1:IW] == {job_r.req.decision_var, job_r.req.low_child,
                                    job_r.req.high_child}) begin
            res_r   <= '{node_id: 16'(cur_r), created: 1'b0, exhausted: 1'b0};
            state_r <= S_OUT;
          end else if (nd_rdata[IW-1:0] != '0) begin
            cur_r   <= nd_rdata[IW-1:0];
            state_r <= S_HEAD;   // back through S_HEAD so the next read settles
          end else if (refuse) begin
            res_r   <= '{node_id: 16'd0, created: 1'b0, exhausted: 1'b1};
            state_r <= S_OUT;
          end else begin
            cur_r   <= head_r;
            state_r <= S_LINK;
          end
        end
        S_LINK: begin
          count_r <= count_r + 1'b1;
          res_r   <= '{node_id: 16'(new_id), created: 1'b1, exhausted: 1'b0};
          state_r <= S_OUT;
        end
        default: begin
          // load the output slot once it is free or being popped
          if (!rsp_valid_r || out_pop) begin
            rsp_r   <= res_r;
            state_r <= S_IDLE;
          end
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/bdd_unique_node_table.sv
// ----------------------------------------------------------------------------
// bdd_unique_node_table: hash-consing unique table for reduced ordered BDDs
// Push (var, low, high) requests; pop one result per request with the
// canonical node id and created/exhausted flags.
// Input queue side: in_push/in_full; output side: out_pop/out_empty.
// cfg_we/cfg_data write the node budget (0 = store capacity only).
// Front hashes with three 64-bit multiplies, each a load step and three
// 32x32 partial products, and takes no new request until its job has left.
// Requests with equal children skip the chain walk; otherwise the back reads
// the bucket head, then visits each chain node through S_HEAD and S_NODE.
// Hash and walk overlap through a two-entry job queue, so the front can hash
// the next request while the back walks a chain; the shared multiplier sets
// the pace whenever the back keeps up.
// After reset the back clears all 2^BUCKET_BITS bucket heads, one per cycle;
// requests wait in the front and the job queue meanwhile.
// A stalled pop holds the result and, once the queue fills, raises in_full.
// ----------------------------------------------------------------------------
`default_nettype none
module bdd_unique_node_table #(
  parameter int NODE_CAPACITY = 65536,
  parameter int BUCKET_BITS   = 17
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire bdd_pkg::bdd_req_t in_data,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output bdd_pkg::bdd_rsp_t      out_data,
  input  wire logic              cfg_we,
  input  wire logic [16:0]       cfg_data
);
  import bdd_pkg::*;

  logic [16:0] budget_r;
  logic        f_valid, f_ready, b_valid, b_ready;
  bdd_job_t    f_job, b_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= '0;
    end else if (cfg_we) begin
      budget_r <= cfg_data;
    end
  end

  bdd_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_data(in_data), .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  bdd_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_ready(f_ready),
    .wr_job(f_job), .rd_valid(b_valid), .rd_ready(b_ready), .rd_job(b_job)
  );

  bdd_back #(.NODE_CAPACITY(NODE_CAPACITY), .BUCKET_BITS(BUCKET_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .budget_limit(budget_r), .job_valid(b_valid),
    .job_ready(b_ready), .job(b_job), .out_empty(out_empty), .out_pop(out_pop),
    .out_data(out_data)
  );
endmodule
`default_nettype wire

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the BDD unique node table
// Directed requests cover equal children, first-time inserts, hits, budget
// refusals and budget register extremes; random segments follow, each under
// a new budget. Directed results are checked against listed expectations and
// random ones against an in-bench hash-consing predictor, with push/pop idling.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bdd_pkg::*;

  localparam int NODE_LIMIT   = 65536;
  localparam int HEAD_BITS    = 17;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SEGMENTS     = 9;
  localparam int SEG_ITEMS    = 150;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    bdd_req_t    req;
    bit          typed;
    bdd_rsp_t    rsp;
    logic [16:0] budget;
  } stim_row_t;

  typedef struct {
    bdd_req_t req;
    bit       typed;
    bdd_rsp_t rsp;
  } pending_req_t;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  bdd_req_t    in_data;
  logic        out_empty;
  logic        out_pop;
  bdd_rsp_t    out_data;
  logic        cfg_we;
  logic [16:0] cfg_data;

  bdd_unique_node_table i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Shadow unique table
  bit [7:0]    node_var[int];
  bit [15:0]   node_lo[int];
  bit [15:0]   node_hi[int];
  int          node_link[int];
  int          chain_head[int];
  int          node_count;
  logic [16:0] budget_now;

  stim_row_t    directed_rows[$];
  pending_req_t send_q[$];
  bdd_rsp_t     node_rsp_q[$];
  bdd_req_t     seen_triples[$];

  int fail_count;
  int transfers_in;
  int transfers_out;
  int created_seen;
  int refused_seen;
  int cycle_count;
  int push_idle_pct;
  int pop_idle_pct;

  function automatic int bucket_of(bdd_req_t r);
    longint unsigned h;
    h = HASH_BASIS;
    h = (h ^ longint'(r.decision_var)) * HASH_PRIME;
    h = (h ^ longint'(r.low_child)) * HASH_PRIME;
    h = (h ^ longint'(r.high_child)) * HASH_PRIME;
    h = h ^ (h >> 32);
    return int'(h[HEAD_BITS-1:0]);
  endfunction

  function automatic bdd_rsp_t lookup_or_insert(bdd_req_t r);
    bdd_rsp_t rsp;
    int b;
    int i;
    rsp = '0;
    if (r.low_child == r.high_child) begin
      rsp.node_id = r.low_child;
      return rsp;
    end
    b = bucket_of(r);
    i = chain_head.exists(b) ? chain_head[b] : 0;
    while (i != 0) begin
      if (node_var[i] == r.decision_var && node_lo[i] == r.low_child &&
          node_hi[i] == r.high_child) begin
        rsp.node_id = 16'(i);
        return rsp;
      end
      i = node_link[i];
    end
    if ((budget_now != 0 && node_count >= budget_now) || node_count >= NODE_LIMIT) begin
      rsp.exhausted = 1'b1;
      return rsp;
    end
    i = node_count;
    node_count++;
    node_var[i]  = r.decision_var;
    node_lo[i]   = r.low_child;
    node_hi[i]   = r.high_child;
    node_link[i] = chain_head.exists(b) ? chain_head[b] : 0;
    chain_head[b] = i;
    rsp.node_id = 16'(i);
    rsp.created = 1'b1;
    return rsp;
  endfunction

  task automatic report_mismatch(string what, bdd_rsp_t got, bdd_rsp_t want);
    $display("[%0d] %s: got id=%h c=%b x=%b, want id=%h c=%b x=%b", cycle_count, what,
             got.node_id, got.created, got.exhausted,
             want.node_id, want.created, want.exhausted);
    fail_count++;
  endtask

  task automatic add_req(bit [7:0] v, bit [15:0] lo, bit [15:0] hi, bit typed = 0,
                         bit [15:0] id = 0, bit cr = 0, bit ex = 0);
    stim_row_t row;
    row.kind   = ROW_REQ;
    row.req    = '{decision_var: v, low_child: lo, high_child: hi};
    row.typed  = typed;
    row.rsp    = '{node_id: id, created: cr, exhausted: ex};
    row.budget = '0;
    directed_rows.push_back(row);
  endtask

  task automatic add_cfg(logic [16:0] b);
    stim_row_t row;
    row = '{kind: ROW_CFG, req: '0, typed: 0, rsp: '0, budget: b};
    directed_rows.push_back(row);
  endtask

  task automatic queue_req(bdd_req_t r, bit typed, bdd_rsp_t rsp);
    pending_req_t p;
    p = '{req: r, typed: typed, rsp: rsp};
    send_q.push_back(p);
    seen_triples.push_back(r);
  endtask

  task automatic drain();
    while (send_q.size() != 0 || node_rsp_q.size() != 0 || in_push)
      @(posedge clk);
  endtask

  task automatic write_budget(logic [16:0] b);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= b;
    budget_now = b;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic bdd_req_t random_triple();
    bdd_req_t r;
    int pick;
    pick = $urandom_range(99);
    r.decision_var = 8'($urandom);
    r.low_child    = 16'($urandom);
    r.high_child   = 16'($urandom);
    if (pick < 35 && seen_triples.size() != 0) begin
      r = seen_triples[$urandom_range(seen_triples.size() - 1)];
    end else if (pick < 45) begin
      r.high_child = r.low_child;
    end else if (pick < 75) begin
      // narrow ranges so triples repeat and hit existing nodes
      r.decision_var = 8'($urandom_range(3));
      r.low_child    = 16'($urandom_range(15));
      r.high_child   = 16'($urandom_range(15));
    end
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Request side: predict on each transfer, then offer the next item
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        pending_req_t p;
        bdd_rsp_t     want;
        p = send_q.pop_front();
        want = lookup_or_insert(p.req);
        node_rsp_q.push_back(p.typed ? p.rsp : want);
        transfers_in++;
      end
      if (send_q.size() != 0 && $urandom_range(99) >= push_idle_pct) begin
        in_push <= 1'b1;
        in_data <= send_q[0].req;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Result side
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        bdd_rsp_t want;
        if (node_rsp_q.size() == 0) begin
          report_mismatch("unexpected result", out_data, '0);
        end else begin
          want = node_rsp_q.pop_front();
          if (out_data.node_id != want.node_id)
            report_mismatch("node_id", out_data, want);
          if (out_data.created != want.created)
            report_mismatch("created", out_data, want);
          if (out_data.exhausted != want.exhausted)
            report_mismatch("exhausted", out_data, want);
          created_seen += out_data.created;
          refused_seen += out_data.exhausted;
        end
        transfers_out++;
      end
      out_pop <= ($urandom_range(99) >= pop_idle_pct);
    end
  end

  initial begin
    logic [16:0] b;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    out_pop = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    fail_count = 0;
    transfers_in = 0;
    transfers_out = 0;
    created_seen = 0;
    refused_seen = 0;
    cycle_count = 0;
    node_count = 2;
    budget_now = '0;
    push_idle_pct = 26;
    pop_idle_pct = 64;

    add_req(8'd0,   16'h0000, 16'h0000, 1, 16'h0000, 0, 0);
    add_req(8'd255, 16'hffff, 16'hffff, 1, 16'hffff, 0, 0);
    add_req(8'd0,   16'h0000, 16'h0001, 1, 16'd2, 1, 0);
    add_req(8'd0,   16'h0000, 16'h0001, 1, 16'd2, 0, 0);
    add_req(8'd255, 16'hffff, 16'h0000, 1, 16'd3, 1, 0);
    add_req(8'd255, 16'h0000, 16'hffff, 1, 16'd4, 1, 0);
    add_req(8'd1,   16'h0002, 16'h0003, 1, 16'd5, 1, 0);
    add_req(8'd0,   16'h0001, 16'h0000, 1, 16'd6, 1, 0);
    add_cfg(17'd7);
    add_req(8'd7,   16'h0008, 16'h0009, 1, 16'd0, 0, 1);
    add_req(8'd255, 16'hffff, 16'h0000, 1, 16'd3, 0, 0);
    add_cfg(17'd1);
    add_req(8'd2,   16'h0001, 16'h0000, 1, 16'd0, 0, 1);
    add_req(8'd2,   16'h0002, 16'h0002, 1, 16'd2, 0, 0);
    add_cfg(17'd65536);
    add_req(8'd128, 16'haaaa, 16'h5555);
    add_req(8'd127, 16'h5555, 16'haaaa);
    add_cfg(17'h1ffff);
    add_req(8'd7,   16'h0008, 16'h0009);
    add_cfg(17'd0);
    add_req(8'd0,   16'h0001, 16'h0000, 1, 16'd6, 0, 0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_CFG)
        write_budget(directed_rows[k].budget);
      else
        queue_req(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].rsp);
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      push_idle_pct = (seg < 3) ? 26 : (seg < 6) ? 64 : 0;
      pop_idle_pct  = (seg < 3) ? 64 : (seg < 6) ? 26 : 0;
      case ($urandom_range(3))
        0: b = 17'd0;
        1: b = 17'(node_count + $urandom_range(5, 60));
        2: b = 17'd65536;
        default: b = 17'h1ffff;
      endcase
      write_budget(b);
      repeat (SEG_ITEMS) queue_req(random_triple(), 0, '0);
      // hold the last segment without idling for a stretch
      if (seg == SEGMENTS - 1) begin
        push_idle_pct = 0;
        pop_idle_pct = 0;
      end
    end

    drain();
    repeat (60) @(posedge clk);
    if (node_rsp_q.size() != 0) begin
      $display("%0d results never arrived", node_rsp_q.size());
      fail_count++;
    end
    $display("requests %0d, results %0d, nodes made %0d, refusals %0d",
             transfers_in, transfers_out, created_seen, refused_seen);
    $display("shadow table holds %0d ids across budget changes and idling modes", node_count);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
hw/rtl/bdd_pkg.sv
hw/rtl/bdd_ram.sv
hw/rtl/bdd_front.sv
hw/rtl/bdd_queue.sv
hw/rtl/bdd_back.sv
hw/rtl/bdd_unique_node_table.sv
verif/tb.sv
